// ----- hw/rtl/pidl_pkg.sv -----
// ----------------------------------------------------------------------------
// pidl_pkg
// Shared types and constants for the positional insert/delete list.
// ----------------------------------------------------------------------------
package pidl_pkg;

   localparam int DEPTH       = 64;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int GROUP_SIZE  = 8;
   localparam int NUM_GROUPS  = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [1:0] CMD_INSERT = 2'd0;
   localparam logic [1:0] CMD_DELETE = 2'd1;
   localparam logic [1:0] CMD_GET    = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
   } op_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [CNT_W-1:0] count;
      logic             rd_en;
   } result_type;

endpackage

// ----- hw/rtl/positional_insert_delete_list_core.sv -----
// ----------------------------------------------------------------------------
// positional_insert_delete_list_core
// Ordered list of signed words in a row of shifting cells, with insert,
// delete and get by position.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid/ready, req_cmd/index/value    | in
//   response| rsp_valid/ready, rsp_data/status/count  | out
//
// One item is taken per cycle unless the response stalls; its response is
// registered in stage 1, then in the output stage. The cells shift in the
// accept cycle; the read is a registered two-level OR tree over the cells.
// Synchronous reset empties the list; cell contents are not cleared.
// A stalled response holds the pipe; the request side stalls when it is full.
// ----------------------------------------------------------------------------
module positional_insert_delete_list_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_cmd,
   input  logic [5:0]                         req_index,
   input  logic signed [pidl_pkg::DATA_W-1:0] req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [pidl_pkg::DATA_W-1:0] rsp_data,
   output logic [1:0]                         rsp_status,
   output logic [6:0]                         rsp_count
);

   logic                         accept;
   logic                         s1_move;
   pidl_pkg::op_type             op;
   pidl_pkg::result_type         result;

   logic signed [pidl_pkg::DATA_W-1:0] cell_entry [pidl_pkg::DEPTH];
   logic [pidl_pkg::DATA_W-1:0]        cell_sel   [pidl_pkg::DEPTH];
   logic [pidl_pkg::DATA_W-1:0]        grp_in     [pidl_pkg::NUM_GROUPS];
   logic [pidl_pkg::DATA_W-1:0]        grp_ff     [pidl_pkg::NUM_GROUPS];
   logic [pidl_pkg::DATA_W-1:0]        rd_word;

   logic                         s1_valid_ff;
   pidl_pkg::result_type         s1_res_ff;
   logic                         rsp_valid_ff;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_data_ff;
   logic [1:0]                   rsp_status_ff;
   logic [pidl_pkg::CNT_W-1:0]   rsp_count_ff;

   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   pidl_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .cmd    (req_cmd),
      .index  (req_index),
      .value  (req_value),
      .op     (op),
      .result (result)
   );

   for (genvar i = 0; i < pidl_pkg::DEPTH; i++) begin : g_cell
      logic signed [pidl_pkg::DATA_W-1:0] left_w;
      logic signed [pidl_pkg::DATA_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_entry[i-1];
      end
      if (i == pidl_pkg::DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_entry[i+1];
      end
      pidl_cell u_cell (
         .clock     (clock),
         .op        (op),
         .pos       (pidl_pkg::IDX_W'(i)),
         .left_in   (left_w),
         .right_in  (right_w),
         .entry_out (cell_entry[i]),
         .sel_out   (cell_sel[i])
      );
   end

   always_comb begin
      for (int g = 0; g < pidl_pkg::NUM_GROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < pidl_pkg::GROUP_SIZE; k++) begin
            if (g * pidl_pkg::GROUP_SIZE + k < pidl_pkg::DEPTH) begin
               grp_in[g] = grp_in[g] | cell_sel[g * pidl_pkg::GROUP_SIZE + k];
            end
         end
      end
   end

   always_comb begin
      rd_word = '0;
      for (int g = 0; g < pidl_pkg::NUM_GROUPS; g++) begin
         rd_word = rd_word | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_res_ff <= result;
         grp_ff    <= grp_in;
      end
      if (s1_move) begin
         rsp_data_ff   <= s1_res_ff.rd_en ? rd_word : '0;
         rsp_status_ff <= s1_res_ff.status;
         rsp_count_ff  <= s1_res_ff.count;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_count  = 7'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_count <= 7'(pidl_pkg::DEPTH)))
      else $error("count above depth");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != pidl_pkg::ST_OK)) |-> (rsp_data == '0))
      else $error("error response with nonzero data");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == pidl_pkg::ST_FULL)) |->
         (rsp_count == 7'(pidl_pkg::DEPTH)))
      else $error("full status with list not full");

   a_stall_ready: assert property (@(posedge clock) disable iff (reset)
      (!req_ready) |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request side stalled without backpressure");

endmodule

// ----- hw/rtl/pidl_cell.sv -----
// ----------------------------------------------------------------------------
// pidl_cell
// One list slot: holds a word and shifts with its neighbors on insert/delete.
// ----------------------------------------------------------------------------
module pidl_cell (
   input  logic                                    clock,
   input  pidl_pkg::op_type                        op,
   input  logic [pidl_pkg::IDX_W-1:0]              pos,
   input  logic signed [pidl_pkg::DATA_W-1:0]      left_in,
   input  logic signed [pidl_pkg::DATA_W-1:0]      right_in,
   output logic signed [pidl_pkg::DATA_W-1:0]      entry_out,
   output logic [pidl_pkg::DATA_W-1:0]             sel_out
);

   logic signed [pidl_pkg::DATA_W-1:0] entry_ff;
   logic signed [pidl_pkg::DATA_W-1:0] entry_in;
   logic                               at_idx;
   logic                               past_idx;

   assign at_idx   = (pos == op.idx);
   assign past_idx = (pos > op.idx);

   always_comb begin
      entry_in = entry_ff;
      if (op.ins && at_idx) begin
         entry_in = op.value;
      end else if (op.ins && past_idx) begin
         entry_in = left_in;
      end else if (op.del && (at_idx || past_idx)) begin
         entry_in = right_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
   assign sel_out   = at_idx ? entry_ff : '0;

endmodule

// ----- hw/rtl/pidl_ctrl.sv -----
// ----------------------------------------------------------------------------
// pidl_ctrl
// Entry count, index checks and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
module pidl_ctrl (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [1:0]                         cmd,
   input  logic [5:0]                         index,
   input  logic signed [pidl_pkg::DATA_W-1:0] value,
   output pidl_pkg::op_type                   op,
   output pidl_pkg::result_type               result
);

   logic [pidl_pkg::CNT_W-1:0] count_ff;
   logic [pidl_pkg::CNT_W-1:0] count_in;
   logic [pidl_pkg::CNT_W-1:0] idx_ext;
   logic [1:0]                 status;
   logic                       do_ins;
   logic                       do_del;
   logic                       rd_en;

   assign idx_ext = pidl_pkg::CNT_W'(index);

   always_comb begin
      status = pidl_pkg::ST_OK;
      do_ins = 1'b0;
      do_del = 1'b0;
      rd_en  = 1'b0;
      unique case (cmd)
         pidl_pkg::CMD_INSERT: begin
            priority if (idx_ext > count_ff) begin
               status = pidl_pkg::ST_RANGE;
            end else if (count_ff == pidl_pkg::CNT_W'(pidl_pkg::DEPTH)) begin
               status = pidl_pkg::ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         pidl_pkg::CMD_DELETE: begin
            if (idx_ext >= count_ff) begin
               status = pidl_pkg::ST_RANGE;
            end else begin
               do_del = 1'b1;
               rd_en  = 1'b1;
            end
         end
         pidl_pkg::CMD_GET: begin
            if (idx_ext >= count_ff) begin
               status = pidl_pkg::ST_RANGE;
            end else begin
               rd_en = 1'b1;
            end
         end
         default: begin
            status = pidl_pkg::ST_RANGE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && do_ins) begin
         count_in = count_ff + pidl_pkg::CNT_W'(1);
      end else if (accept && do_del) begin
         count_in = count_ff - pidl_pkg::CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign op.ins   = accept && do_ins;
   assign op.del   = accept && do_del;
   assign op.idx   = pidl_pkg::IDX_W'(index);
   assign op.value = value;

   assign result.status = status;
   assign result.count  = count_in;
   assign result.rd_en  = rd_en;

endmodule

// ----- tb/tb_positional_insert_delete_list_core.sv -----
// ----------------------------------------------------------------------------
// tb_positional_insert_delete_list_core
// Self-checking bench for the positional insert/delete list core. A shadow
// list predicts data, status and count for every accepted request, and the
// responses are compared in order. Directed items cover the value extremes,
// the empty and out-of-range cases and the unused command code. Random
// traffic then runs in grow, mixed, shrink and noise segments so the list
// fills up, hits the full case and drains again, under bursty requests and
// patterned response stalls.
// ----------------------------------------------------------------------------
module tb_positional_insert_delete_list_core;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         N_RANDOM   = 1300;
   localparam int         TAIL_CYC   = 20;

   typedef struct packed {
      logic signed [pidl_pkg::DATA_W-1:0] data;
      logic [1:0]                         status;
      logic [6:0]                         count;
   } list_rsp_type;

   typedef enum int {REG_GROW, REG_MIXED, REG_SHRINK, REG_NOISE} regime_type;

   class list_scoreboard;
      logic signed [pidl_pkg::DATA_W-1:0] cells [pidl_pkg::DEPTH];
      int                                 fill;
      list_rsp_type                       awaited [$];
      int                                 mismatches;

      function new();
         fill       = 0;
         mismatches = 0;
      endfunction

      function void note_request(logic [1:0] cmd, logic [5:0] idx,
                                 logic signed [pidl_pkg::DATA_W-1:0] val);
         list_rsp_type r;
         int           pos;
         pos      = int'(idx);
         r.data   = '0;
         r.status = pidl_pkg::ST_OK;
         case (cmd)
            pidl_pkg::CMD_INSERT: begin
               if (pos > fill) begin
                  r.status = pidl_pkg::ST_RANGE;
               end else if (fill >= pidl_pkg::DEPTH) begin
                  r.status = pidl_pkg::ST_FULL;
               end else begin
                  for (int i = fill; i > pos; i--) cells[i] = cells[i-1];
                  cells[pos] = val;
                  fill++;
               end
            end
            pidl_pkg::CMD_DELETE: begin
               if (pos >= fill) begin
                  r.status = pidl_pkg::ST_RANGE;
               end else begin
                  r.data = cells[pos];
                  for (int i = pos; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
            pidl_pkg::CMD_GET: begin
               if (pos >= fill) r.status = pidl_pkg::ST_RANGE;
               else r.data = cells[pos];
            end
            default: begin
               r.status = pidl_pkg::ST_RANGE;
            end
         endcase
         r.count = 7'(fill);
         awaited.push_back(r);
      endfunction

      task report(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_response(logic signed [pidl_pkg::DATA_W-1:0] data,
                          logic [1:0] status, logic [6:0] count);
         list_rsp_type e;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected item data=%0d status=%0d count=%0d",
                             data, status, count));
            return;
         end
         e = awaited.pop_front();
         if (data !== e.data)
            report($sformatf("data %0d, expected %0d", data, e.data));
         if (status !== e.status)
            report($sformatf("status %0d, expected %0d", status, e.status));
         if (count !== e.count)
            report($sformatf("count %0d, expected %0d", count, e.count));
      endtask
   endclass

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [1:0]                         req_cmd;
   logic [5:0]                         req_index;
   logic signed [pidl_pkg::DATA_W-1:0] req_value;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic signed [pidl_pkg::DATA_W-1:0] rsp_data;
   logic [1:0]                         rsp_status;
   logic [6:0]                         rsp_count;

   list_scoreboard sb = new();
   int             burst_left = 0;
   int             stall_left = 0;
   int             stall_mode = 0;

   positional_insert_delete_list_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_cmd    (req_cmd),
      .req_index  (req_index),
      .req_value  (req_value),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #3_200_000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(1, 40);
      end
      stall_left--;
      case (stall_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ((stall_left % 8) < 2);
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_data, rsp_status, rsp_count);
   end

   task automatic send_item(input logic [1:0] cmd, input logic [5:0] idx,
                            input logic signed [pidl_pkg::DATA_W-1:0] val);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_cmd   <= cmd;
      req_index <= idx;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, idx, val);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(0, 24);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
   endtask

   task automatic random_item(input regime_type regime);
      logic [1:0]                         cmd;
      logic [5:0]                         idx;
      logic signed [pidl_pkg::DATA_W-1:0] val;
      int                                 roll;
      int                                 hi;
      roll = $urandom_range(0, 99);
      if (regime == REG_NOISE || $urandom_range(0, 9) == 0) begin
         cmd = 2'($urandom_range(0, 3));
         idx = 6'($urandom_range(0, 63));
      end else begin
         case (regime)
            REG_GROW:   cmd = (roll < 85) ? pidl_pkg::CMD_INSERT :
                              (roll < 92) ? pidl_pkg::CMD_DELETE : pidl_pkg::CMD_GET;
            REG_SHRINK: cmd = (roll < 20) ? pidl_pkg::CMD_INSERT :
                              (roll < 80) ? pidl_pkg::CMD_DELETE : pidl_pkg::CMD_GET;
            default:    cmd = (roll < 40) ? pidl_pkg::CMD_INSERT :
                              (roll < 70) ? pidl_pkg::CMD_DELETE : pidl_pkg::CMD_GET;
         endcase
         if (cmd == pidl_pkg::CMD_INSERT) hi = (sb.fill > 63) ? 63 : sb.fill;
         else hi = sb.fill - 1;
         if (hi < 0) begin
            idx = 6'($urandom_range(0, 63));
         end else begin
            case ($urandom_range(0, 3))
               0:       idx = '0;
               1:       idx = 6'(hi);
               default: idx = 6'($urandom_range(0, hi));
            endcase
         end
      end
      case ($urandom_range(0, 7))
         0:       val = 32'sh8000_0000;
         1:       val = 32'sh7fff_ffff;
         2:       val = '0;
         3:       val = -32'sd1;
         default: val = $urandom;
      endcase
      send_item(cmd, idx, val);
   endtask

   initial begin
      int         items;
      int         seg_left;
      regime_type regime;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_cmd   = pidl_pkg::CMD_INSERT;
      req_index = '0;
      req_value = '0;
      rsp_ready = 1'b0;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      send_item(pidl_pkg::CMD_GET,    6'd0,  32'sd5);
      send_item(pidl_pkg::CMD_DELETE, 6'd0,  32'sd5);
      send_item(pidl_pkg::CMD_INSERT, 6'd1,  32'sd9);
      send_item(pidl_pkg::CMD_INSERT, 6'd0,  32'sh7fff_ffff);
      send_item(pidl_pkg::CMD_INSERT, 6'd0,  32'sh8000_0000);
      send_item(pidl_pkg::CMD_INSERT, 6'd2,  32'sd0);
      send_item(pidl_pkg::CMD_INSERT, 6'd1,  -32'sd1);
      send_item(pidl_pkg::CMD_GET,    6'd0,  32'sd0);
      send_item(pidl_pkg::CMD_GET,    6'd3,  32'sh7fff_ffff);
      send_item(pidl_pkg::CMD_GET,    6'd4,  32'sd0);
      send_item(CMD_UNUSED,           6'd0,  32'sd0);
      send_item(CMD_UNUSED,           6'd63, -32'sd1);
      send_item(pidl_pkg::CMD_INSERT, 6'd63, 32'sh5a5a_a5a5);
      send_item(pidl_pkg::CMD_INSERT, 6'd4,  32'sh1234_5678);
      send_item(pidl_pkg::CMD_GET,    6'd63, 32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd1,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd3,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd3,  32'sd0);
      send_item(pidl_pkg::CMD_GET,    6'd2,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd0,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd0,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd0,  32'sd0);
      send_item(pidl_pkg::CMD_DELETE, 6'd0,  32'sd0);
      wait_drained();

      items    = 0;
      regime   = REG_GROW;
      seg_left = 140;
      while (items < N_RANDOM) begin
         if (seg_left == 0) begin
            if ($urandom_range(0, 3) == 0) wait_drained();
            regime   = regime_type'((int'(regime) + 1) % 4);
            seg_left = (regime == REG_GROW) ? $urandom_range(100, 160)
                                            : $urandom_range(40, 140);
         end
         random_item(regime);
         items++;
         seg_left--;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
